// ----- src/scfd_pkg.sv -----
// scfd_pkg: shared types, character codes and parser codes for the serial
// command frame decoder. No dependencies.
`timescale 1ns / 1ps

package scfd_pkg;

    localparam int FRAME_BYTES_DEF = 128;
    localparam int QUEUE_DEPTH     = 2;

    // characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_LC_C   = 8'h63;
    localparam logic [7:0] CH_UC_C   = 8'h43;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // frame stage
    localparam logic [1:0] ST_WAIT   = 2'd0;
    localparam logic [1:0] ST_BSLASH = 2'd1;
    localparam logic [1:0] ST_BODY   = 2'd2;

    // name match
    localparam logic [2:0] NM_EMPTY = 3'd0;
    localparam logic [2:0] NM_M     = 3'd1;
    localparam logic [2:0] NM_S     = 3'd2;
    localparam logic [2:0] NM_MS    = 3'd3;
    localparam logic [2:0] NM_MD    = 3'd4;
    localparam logic [2:0] NM_SP    = 3'd5;
    localparam logic [2:0] NM_OTHER = 3'd6;

    // value phase
    localparam logic [2:0] PH_BEFORE = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_INT    = 3'd2;
    localparam logic [2:0] PH_FRAC1  = 3'd3;
    localparam logic [2:0] PH_FRAC2  = 3'd4;
    localparam logic [2:0] PH_FRACX  = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    // config register indexes
    localparam logic [2:0] CFG_MOTOR_TOP = 3'd0;
    localparam logic [2:0] CFG_MOTOR_INV = 3'd1;
    localparam logic [2:0] CFG_TICK_RATE = 3'd2;
    localparam logic [2:0] CFG_MIN_US    = 3'd3;
    localparam logic [2:0] CFG_MAX_US    = 3'd4;

    localparam logic [13:0] HUND_FULL = 14'd10000;
    // x / 10000 as (x >> 4) * ceil(2^28 / 625) >> 28, exact for x below 2^22
    localparam logic [18:0] MOTOR_RECIP = 19'd429497;
    // x / 1e8 as (x >> 8) * ceil(2^46 / 390625) >> 46, exact for x below 2^35
    localparam logic [27:0] SERVO_RECIP = 28'd180143986;
    localparam logic [34:0] SERVO_SAT = 35'd25600000000;

    // one closed frame handed from parser to executor
    typedef struct packed {
        logic        spd_v;
        logic [13:0] spd;
        logic        dir_v;
        logic        dir;
        logic        srv_v;
        logic [6:0]  srv;
        logic [6:0]  cnt;
    } t_commit;

endpackage

// ----- src/scfd_queue.sv -----
// scfd_queue: small fifo of closed frames between parser and executor.
// Depends on scfd_pkg.
`timescale 1ns / 1ps

module scfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scfd_pkg::t_commit i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output scfd_pkg::t_commit o_data
);
    localparam int DEPTH = scfd_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    scfd_pkg::t_commit r_mem [DEPTH];
    logic [AW-1:0]     r_wptr, r_rptr;
    logic [AW:0]       r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

// ----- src/scfd_front.sv -----
// scfd_front: byte parser, frame detection, name and value scanning and the
// pending command set; pushes one record per closing slash. Depends on scfd_pkg.
`timescale 1ns / 1ps

module scfd_front #(
    parameter int FRAME_BYTES = scfd_pkg::FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output scfd_pkg::t_commit o_rec
);
    localparam int BW = $clog2(FRAME_BYTES + 1);

    logic [1:0]    r_stage, n_stage;
    logic [BW-1:0] r_bcnt, n_bcnt;
    logic          r_inval, n_inval;
    logic [2:0]    r_name, n_name;
    logic          r_sign, n_sign;
    logic [7:0]    r_int, n_int;
    logic [6:0]    r_frac, n_frac;
    logic [2:0]    r_phase, n_phase;
    logic [14:0]   r_pspd, n_pspd;
    logic [1:0]    r_pdir, n_pdir;
    logic [7:0]    r_psrv, n_psrv;
    logic [6:0]    r_cnt, n_cnt;

    // result of closing the current command
    logic [14:0] ec_spd;
    logic [1:0]  ec_dir;
    logic [7:0]  ec_srv;
    logic [6:0]  ec_cnt;
    logic        known;

    logic        digit, ws, num_path;
    logic [3:0]  d;
    logic [11:0] v;

    always_comb begin
        ec_spd = r_pspd;
        ec_dir = r_pdir;
        ec_srv = r_psrv;
        known  = 1'b1;
        priority if (r_name == scfd_pkg::NM_MS) begin
            if (r_sign) begin
                ec_spd = {1'b1, 14'd0};
            end else if (r_int >= 8'd100) begin
                ec_spd = {1'b1, scfd_pkg::HUND_FULL};
            end else begin
                ec_spd = {1'b1, 14'(r_int * 14'd100) + 14'(r_frac)};
            end
        end else if (r_name == scfd_pkg::NM_MD) begin
            ec_dir = {1'b1, r_int != 8'd0};
        end else if (r_name == scfd_pkg::NM_SP) begin
            ec_srv = {1'b1, r_sign ? 7'd0 : (r_int > 8'd100 ? 7'd100 : r_int[6:0])};
        end else begin
            known = 1'b0;
        end
        ec_cnt = (known && r_cnt != 7'd127) ? r_cnt + 7'd1 : r_cnt;
    end

    assign digit = (i_byte >= scfd_pkg::CH_ZERO) && (i_byte <= scfd_pkg::CH_NINE);
    assign d     = digit ? 4'(i_byte - scfd_pkg::CH_ZERO) : 4'd0;
    assign ws    = (i_byte == scfd_pkg::CH_SPACE) ||
                   ((i_byte >= scfd_pkg::CH_TAB) && (i_byte <= scfd_pkg::CH_CR));
    assign v     = 12'(r_int) * 12'd10 + 12'(d);
    assign num_path = (r_phase == scfd_pkg::PH_SIGN) || (r_phase == scfd_pkg::PH_INT) ||
                      ((r_phase == scfd_pkg::PH_BEFORE) && !ws &&
                       (i_byte != scfd_pkg::CH_PLUS) && (i_byte != scfd_pkg::CH_MINUS));

    always_comb begin
        n_stage = r_stage;
        n_bcnt  = r_bcnt;
        n_inval = r_inval;
        n_name  = r_name;
        n_sign  = r_sign;
        n_int   = r_int;
        n_frac  = r_frac;
        n_phase = r_phase;
        n_pspd  = r_pspd;
        n_pdir  = r_pdir;
        n_psrv  = r_psrv;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_rec   = '{spd_v: ec_spd[14], spd: ec_spd[13:0], dir_v: ec_dir[1], dir: ec_dir[0],
                    srv_v: ec_srv[7], srv: ec_srv[6:0], cnt: ec_cnt};
        if (i_valid) begin
            if (r_stage == scfd_pkg::ST_WAIT) begin
                if (i_byte == scfd_pkg::CH_BSLASH) begin
                    n_stage = scfd_pkg::ST_BSLASH;
                end
            end else if (r_stage == scfd_pkg::ST_BSLASH) begin
                n_stage = ((i_byte == scfd_pkg::CH_LC_C) || (i_byte == scfd_pkg::CH_UC_C))
                          ? scfd_pkg::ST_BODY : scfd_pkg::ST_WAIT;
                n_bcnt = '0; n_inval = 1'b0; n_name = scfd_pkg::NM_EMPTY; n_sign = 1'b0;
                n_int = '0; n_frac = '0; n_phase = scfd_pkg::PH_BEFORE;
                n_pspd = '0; n_pdir = '0; n_psrv = '0; n_cnt = '0;
            end else if (i_byte == scfd_pkg::CH_SLASH) begin
                o_push  = 1'b1;
                n_stage = scfd_pkg::ST_WAIT;
                n_bcnt = '0; n_inval = 1'b0; n_name = scfd_pkg::NM_EMPTY; n_sign = 1'b0;
                n_int = '0; n_frac = '0; n_phase = scfd_pkg::PH_BEFORE;
                n_pspd = '0; n_pdir = '0; n_psrv = '0; n_cnt = '0;
            end else begin
                if (i_byte == scfd_pkg::CH_EQ) begin
                    n_inval = 1'b1;
                end else if (i_byte == scfd_pkg::CH_BAR) begin
                    n_pspd = ec_spd; n_pdir = ec_dir; n_psrv = ec_srv; n_cnt = ec_cnt;
                    n_inval = 1'b0; n_name = scfd_pkg::NM_EMPTY; n_sign = 1'b0;
                    n_int = '0; n_frac = '0; n_phase = scfd_pkg::PH_BEFORE;
                end else if (i_byte != 8'd0) begin
                    if (r_inval) begin
                        if (num_path) begin
                            if (digit) begin
                                n_int   = (v > 12'd255) ? 8'd255 : v[7:0];
                                n_phase = scfd_pkg::PH_INT;
                            end else if (i_byte == scfd_pkg::CH_DOT) begin
                                n_phase = scfd_pkg::PH_FRAC1;
                            end else begin
                                n_phase = scfd_pkg::PH_DONE;
                            end
                        end else if (r_phase == scfd_pkg::PH_BEFORE) begin
                            // white space stays, a sign moves on
                            if (i_byte == scfd_pkg::CH_PLUS) begin
                                n_phase = scfd_pkg::PH_SIGN;
                            end else if (i_byte == scfd_pkg::CH_MINUS) begin
                                n_sign  = 1'b1;
                                n_phase = scfd_pkg::PH_SIGN;
                            end
                        end else if (r_phase == scfd_pkg::PH_FRAC1) begin
                            if (digit) begin
                                n_frac  = 7'(d) * 7'd10;
                                n_phase = scfd_pkg::PH_FRAC2;
                            end else begin
                                n_phase = scfd_pkg::PH_DONE;
                            end
                        end else if (r_phase == scfd_pkg::PH_FRAC2) begin
                            if (digit) begin
                                n_frac  = r_frac + 7'(d);
                                n_phase = scfd_pkg::PH_FRACX;
                            end else begin
                                n_phase = scfd_pkg::PH_DONE;
                            end
                        end else if (r_phase == scfd_pkg::PH_FRACX) begin
                            if (!digit) begin
                                n_phase = scfd_pkg::PH_DONE;
                            end
                        end
                    end else begin
                        unique case (r_name)
                            scfd_pkg::NM_EMPTY: begin
                                n_name = (i_byte == scfd_pkg::CH_M) ? scfd_pkg::NM_M :
                                         (i_byte == scfd_pkg::CH_S) ? scfd_pkg::NM_S :
                                         scfd_pkg::NM_OTHER;
                            end
                            scfd_pkg::NM_M: begin
                                n_name = (i_byte == scfd_pkg::CH_S) ? scfd_pkg::NM_MS :
                                         (i_byte == scfd_pkg::CH_D) ? scfd_pkg::NM_MD :
                                         scfd_pkg::NM_OTHER;
                            end
                            scfd_pkg::NM_S: begin
                                n_name = (i_byte == scfd_pkg::CH_P) ? scfd_pkg::NM_SP :
                                         scfd_pkg::NM_OTHER;
                            end
                            default: begin
                                n_name = scfd_pkg::NM_OTHER;
                            end
                        endcase
                    end
                end
                // overlong frame is dropped with everything pending
                if ((r_bcnt + 1'b1) >= BW'(FRAME_BYTES)) begin
                    n_stage = scfd_pkg::ST_WAIT;
                    n_bcnt = '0; n_inval = 1'b0; n_name = scfd_pkg::NM_EMPTY; n_sign = 1'b0;
                    n_int = '0; n_frac = '0; n_phase = scfd_pkg::PH_BEFORE;
                    n_pspd = '0; n_pdir = '0; n_psrv = '0; n_cnt = '0;
                end else begin
                    n_bcnt = r_bcnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= scfd_pkg::ST_WAIT;
            r_bcnt  <= '0;
            r_inval <= 1'b0;
            r_name  <= scfd_pkg::NM_EMPTY;
            r_sign  <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_phase <= scfd_pkg::PH_BEFORE;
            r_pspd  <= '0;
            r_pdir  <= '0;
            r_psrv  <= '0;
            r_cnt   <= '0;
        end else begin
            r_stage <= n_stage;
            r_bcnt  <= n_bcnt;
            r_inval <= n_inval;
            r_name  <= n_name;
            r_sign  <= n_sign;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_phase <= n_phase;
            r_pspd  <= n_pspd;
            r_pdir  <= n_pdir;
            r_psrv  <= n_psrv;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- src/scfd_back.sv -----
// scfd_back: config registers, frame commit with motor and servo scaling
// through short multiply steps and reciprocal scaling, output register. Depends on scfd_pkg.
`timescale 1ns / 1ps

module scfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_empty,
    input  scfd_pkg::t_commit i_rec,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [23:0]       o_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_MUL3 = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [7:0]  r_top;
    logic        r_inv;
    logic [15:0] r_rate;
    logic [12:0] r_min, r_max;

    logic [2:0]        r_state;
    scfd_pkg::t_commit r_rec;
    logic [21:0]       r_mrem;
    logic [34:0]       r_srem;
    logic [18:0]       r_na, r_nb, r_num;
    logic [7:0]        r_mq, r_sq;
    logic              r_ssat;
    logic [7:0]        r_motor, r_servo;
    logic              r_dir;
    logic              r_ovalid;
    logic [23:0]       r_odata;

    logic [13:0] p;
    logic [36:0] mprod;
    logic [54:0] sprod;

    assign p     = r_inv ? scfd_pkg::HUND_FULL - r_rec.spd : r_rec.spd;
    assign mprod = 37'(r_mrem[21:4]) * 37'(scfd_pkg::MOTOR_RECIP);
    assign sprod = 55'(r_srem[34:8]) * 55'(scfd_pkg::SERVO_RECIP);
    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= 8'd255;
            r_inv  <= 1'b1;
            r_rate <= 16'd14399;
            r_min  <= 13'd800;
            r_max  <= 13'd2300;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scfd_pkg::CFG_MOTOR_TOP: r_top  <= i_cfg_data[7:0];
                scfd_pkg::CFG_MOTOR_INV: r_inv  <= i_cfg_data[0];
                scfd_pkg::CFG_TICK_RATE: r_rate <= i_cfg_data;
                scfd_pkg::CFG_MIN_US:    r_min  <= i_cfg_data[12:0];
                scfd_pkg::CFG_MAX_US:    r_max  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_rec  <= i_rec;
            end
            S_MUL1: begin
                r_mrem <= 22'(r_top) * 22'(p);
                r_na   <= 19'(r_min) * 19'(7'd100 - r_rec.srv);
            end
            S_MUL2: r_nb   <= 19'(r_max) * 19'(r_rec.srv);
            S_ADD:  r_num  <= r_na + r_nb;
            S_MUL3: r_srem <= 35'(r_num) * 35'(r_rate);
            S_DIV: begin
                // both divisions by constants through reciprocal products
                r_mq   <= mprod[35:28];
                r_sq   <= sprod[53:46];
                r_ssat <= r_srem >= scfd_pkg::SERVO_SAT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_motor  <= 8'd255;
            r_dir    <= 1'b0;
            r_servo  <= 8'd233;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (!i_empty) r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_ADD;
                S_ADD:  r_state <= S_MUL3;
                S_MUL3: r_state <= S_DIV;
                S_DIV:  r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        if (r_rec.spd_v) r_motor <= r_mq;
                        if (r_rec.dir_v) r_dir   <= r_rec.dir;
                        if (r_rec.srv_v) r_servo <= 8'd255 - (r_ssat ? 8'd255 : r_sq);
                        r_odata  <= {r_rec.cnt,
                                     r_rec.srv_v ? 8'd255 - (r_ssat ? 8'd255 : r_sq) : r_servo,
                                     r_rec.dir_v ? r_rec.dir : r_dir,
                                     r_rec.spd_v ? r_mq : r_motor};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/serial_command_frame_decoder_core.sv -----
// Serial command frame decoder: parses \c ... / frames of name=value commands
// into motor and servo compare values. Depends on scfd_pkg and the scfd modules.
`timescale 1ns / 1ps

// The parser takes one received byte per clock while its frame queue has room.
// A closing slash queues the frame; the executor then takes it through its
// steps in order (pop, three multiplies, one add, one reciprocal-scaling step
// for both divisions and output load), and the two-entry queue plus the output
// register let the parser keep reading the next frame meanwhile. A stalled
// result word holds the executor in its output step.
module serial_command_frame_decoder_core #(
    parameter int FRAME_BYTES = scfd_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] motor_compare, [8] motor_direction,
                                       // [16:9] servo_compare, [23:17] commands_done
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    logic              push, full, pop, empty, acc;
    scfd_pkg::t_commit rec_in, rec_out;

    assign s_axis_tready = !full;
    assign acc           = s_axis_tvalid && !full;

    scfd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_byte  (s_axis_tdata),
        .o_push  (push),
        .o_rec   (rec_in)
    );

    scfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (rec_out)
    );

    scfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_empty    (empty),
        .i_rec      (rec_out),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

// ----- src/scfd_checker.sv -----
// scfd_checker: port-level assertions for the decoder, bound to the top level.
// Depends on serial_command_frame_decoder_core.
`timescale 1ns / 1ps

module scfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // a waiting result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // empty frame queue after reset
    a_rst_rdy: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind serial_command_frame_decoder_core scfd_checker u_scfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
